/* design/mtre_pkg.sv */
// Shared constants, register indexes and colour conversion for the tile expander.
package mtre_pkg;

  // Default coordinate width of the screen origin
  localparam int COORD_BITS_DEF = 10;

  // Tile geometry
  localparam int TILE_DIM  = 8;
  localparam int TILE_PIX  = TILE_DIM * TILE_DIM;
  localparam int COL_BITS  = $clog2(TILE_DIM);
  localparam int PIX_BITS  = $clog2(TILE_PIX);

  // Configuration register port
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FORE_RGB = 1'b0,
    CFG_BACK_RGB = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_DATA_BITS-1:0] FORE_RST = 24'hFF_FFFF;
  localparam logic [CFG_DATA_BITS-1:0] BACK_RST = 24'h00_0000;

  // Reduce 24-bit RGB to RGB565 and swap its two bytes
  function automatic logic [15:0] rgb_to_swapped565(input logic [23:0] rgb);
    logic [15:0] c;
    c = {rgb[23:19], rgb[15:10], rgb[7:3]};
    return {c[7:0], c[15:8]};
  endfunction

endpackage

/* design/mono_tile_to_rgb565_expander.sv */
// Top level: collects 8x8 monochrome tiles and streams them out as RGB565 pixels.
//
// Input channel (in_*): one bitmap byte per transaction, one tile column each.
// in_first starts a new bitmap and latches origin and size; a restart drops the
// tile being collected. Output channel (out_*): one pixel per transaction,
// 64 per tile in row-major order, each tagged with the tile window origin.
// Configuration (cfg_*): write fore/back colour while the block is idle.
//
// The first pixel of a tile is on the output the cycle after its
// eighth byte is accepted. Throughput is set by the 64-bit pixel shift
// register, which hands out one pixel per cycle while out_stall is low. The
// first seven bytes of the next tile are taken while the current one drains;
// the eighth is stalled until the last pixel of the current tile is accepted.
//
// Reset: colours return to white on black, geometry to zero (every tile is then
// a final tile at offset 0), no pixels pending.
// A stalled output holds its pixel; input stall follows from it only on the
// eighth byte of a tile.
module mono_tile_to_rgb565_expander
  import mtre_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // input bytes
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_bitmap_byte,
  input  logic                     in_first,
  input  logic [COORD_BITS-1:0]    in_origin_x,
  input  logic [COORD_BITS-1:0]    in_origin_y,
  input  logic [COORD_BITS:0]      in_width_px,
  input  logic [COORD_BITS:0]      in_height_px,
  // output pixels
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [COORD_BITS:0]      out_tile_x,
  output logic [COORD_BITS:0]      out_tile_y,
  output logic [15:0]              out_pixel_color,
  output logic                     out_last_in_tile,
  output logic                     out_last_in_bitmap
);

  localparam int DIM = COORD_BITS + 1;

  // Colour registers
  logic [CFG_DATA_BITS-1:0] fore_r, back_r;

  // Collection side
  logic [7:0]            cols_r [TILE_DIM];
  logic [COL_BITS-1:0]   byte_cnt_r, byte_cnt_nxt, wr_col;
  logic [DIM-1:0]        col_off_r, row_off_r, col_off_nxt, row_off_nxt;
  logic [COORD_BITS-1:0] org_x_r, org_y_r;
  logic [DIM-1:0]        width_r, height_r;

  // Emission side
  logic                  busy_r;
  logic [PIX_BITS-1:0]   pix_cnt_r;
  logic [TILE_PIX-1:0]   pix_sr_r;
  logic [DIM-1:0]        tx_r, ty_r;
  logic                  final_r;

  logic                  in_acc, out_acc, out_done, tile_done;
  logic [TILE_PIX-1:0]   tile_bits;
  logic [DIM:0]          next_col, next_row;
  logic                  col_wrap, row_wrap;
  logic [DIM-1:0]        tx_nxt, ty_nxt;

  // Handshakes
  assign out_acc   = out_valid && !out_stall;
  assign out_done  = out_acc && (pix_cnt_r == PIX_BITS'(TILE_PIX - 1));
  assign in_stall  = busy_r && !out_done && (byte_cnt_r == COL_BITS'(TILE_DIM - 1));
  assign in_acc    = in_valid && !in_stall;
  assign tile_done = in_acc && !in_first && (byte_cnt_r == COL_BITS'(TILE_DIM - 1));

  // Column slot and byte count; a restart puts this byte in column 0
  always_comb begin
    wr_col       = in_first ? '0 : byte_cnt_r;
    byte_cnt_nxt = wr_col + COL_BITS'(1);
  end

  // Arrange the tile in row-major order, last column straight from the input
  always_comb begin
    for (int r = 0; r < TILE_DIM; r++) begin
      for (int c = 0; c < TILE_DIM; c++) begin
        tile_bits[r*TILE_DIM + c] = (c == TILE_DIM - 1) ? in_bitmap_byte[r] : cols_r[c][r];
      end
    end
  end

  // Window origin of the completed tile and the offsets of the next one
  always_comb begin
    tx_nxt      = DIM'({1'b0, org_x_r} + col_off_r);
    ty_nxt      = DIM'({1'b0, org_y_r} + row_off_r);
    next_col    = {1'b0, col_off_r} + (DIM+1)'(TILE_DIM);
    next_row    = {1'b0, row_off_r} + (DIM+1)'(TILE_DIM);
    col_wrap    = next_col >= {1'b0, width_r};
    row_wrap    = next_row >= {1'b0, height_r};
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    if (col_wrap) begin
      col_off_nxt = '0;
      row_off_nxt = row_wrap ? '0 : next_row[DIM-1:0];
    end else begin
      col_off_nxt = next_col[DIM-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= FORE_RST;
      back_r <= BACK_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FORE_RGB: fore_r <= cfg_wdata;
        CFG_BACK_RGB: back_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Store columns (no reset needed)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cols_r[wr_col] <= in_bitmap_byte;
    end
  end

  // Byte count, bitmap geometry and tile offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      col_off_r  <= '0;
      row_off_r  <= '0;
      org_x_r    <= '0;
      org_y_r    <= '0;
      width_r    <= '0;
      height_r   <= '0;
    end else if (in_acc) begin
      byte_cnt_r <= byte_cnt_nxt;
      if (in_first) begin
        org_x_r   <= in_origin_x;
        org_y_r   <= in_origin_y;
        width_r   <= in_width_px;
        height_r  <= in_height_px;
        col_off_r <= '0;
        row_off_r <= '0;
      end else if (tile_done) begin
        col_off_r <= col_off_nxt;
        row_off_r <= row_off_nxt;
      end
    end
  end

  // Emission control: load a finished tile, advance one pixel per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pix_cnt_r <= '0;
    end else if (tile_done) begin
      busy_r    <= 1'b1;
      pix_cnt_r <= '0;
    end else if (out_acc) begin
      busy_r    <= !out_done;
      pix_cnt_r <= pix_cnt_r + PIX_BITS'(1);
    end
  end

  // Pixel shift register and tile tag
  always_ff @(posedge clk) begin
    if (tile_done) begin
      pix_sr_r <= tile_bits;
      tx_r     <= tx_nxt;
      ty_r     <= ty_nxt;
      final_r  <= col_wrap && row_wrap;
    end else if (out_acc) begin
      pix_sr_r <= {1'b0, pix_sr_r[TILE_PIX-1:1]};
    end
  end

  // Output drive
  assign out_valid          = busy_r;
  assign out_tile_x         = tx_r;
  assign out_tile_y         = ty_r;
  assign out_pixel_color    = pix_sr_r[0] ? rgb_to_swapped565(fore_r) : rgb_to_swapped565(back_r);
  assign out_last_in_tile   = (pix_cnt_r == PIX_BITS'(TILE_PIX - 1));
  assign out_last_in_bitmap = out_last_in_tile && final_r;

endmodule

/* design/mtre_checker.sv */
// Port-level checker for the tile expander, with its bind.
module mtre_checker
  import mtre_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS:0]   out_tile_x,
  input logic [COORD_BITS:0]   out_tile_y,
  input logic [15:0]           out_pixel_color,
  input logic                  out_last_in_tile,
  input logic                  out_last_in_bitmap
);

  // Final pixel of a bitmap always closes a tile
  a_bitmap_end_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_in_bitmap |-> out_last_in_tile)
    else $error("last_in_bitmap without last_in_tile");

  // A tile drains without gaps once started
  a_tile_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_in_tile |=> out_valid)
    else $error("gap inside a tile");

  // Window origin is constant across the pixels of a tile
  a_tile_origin_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_in_tile |=>
      $stable(out_tile_x) && $stable(out_tile_y))
    else $error("tile origin changed mid-tile");

  // A stalled pixel is held
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_color))
    else $error("stalled pixel changed");

endmodule

bind mono_tile_to_rgb565_expander mtre_checker #(.COORD_BITS(COORD_BITS)) u_mtre_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_tile_x         (out_tile_x),
  .out_tile_y         (out_tile_y),
  .out_pixel_color    (out_pixel_color),
  .out_last_in_tile   (out_last_in_tile),
  .out_last_in_bitmap (out_last_in_bitmap)
);

/* tb/tb_top.sv */
// Self-checking testbench for the monochrome tile to RGB565 pixel expander.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtre_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int CLK_HALF  = 5;
  localparam int TAIL_WAIT = 8;
  localparam int SHOW_MAX  = 10;
  localparam int PHASE_ITEMS = 80;

  // One expected or observed pixel transaction
  typedef struct packed {
    logic [CB:0]  tx;
    logic [CB:0]  ty;
    logic [15:0]  colour;
    logic         last_tile;
    logic         last_bitmap;
  } pixel_t;

  // One row of the directed table; chk rows carry a typed, uniform tile
  typedef struct packed {
    logic [7:0]   data;
    logic         first;
    logic [CB-1:0] ox;
    logic [CB-1:0] oy;
    logic [CB:0]  w;
    logic [CB:0]  h;
    logic         chk;
    logic [CB:0]  ex;
    logic [CB:0]  ey;
    logic [15:0]  ecol;
    logic         elb;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  // Zero geometry after reset, extreme origin and size, restart mid-tile
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b1, 11'd0,    11'd0,    16'hFFFF, 1'b1},
    '{8'h00, 1'b1, 10'd1023, 10'd1023, 11'd1024, 11'd1024, 1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h00, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h00, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h00, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h00, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h00, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h00, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h00, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b1, 11'd1023, 11'd1023, 16'h0000, 1'b0},
    '{8'hAA, 1'b1, 10'd0,    10'd0,    11'd9,    11'd1,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h55, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h01, 1'b1, 10'd5,    10'd7,    11'd1,    11'd1,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h80, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hA5, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h5A, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h0F, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hF0, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'h3C, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0},
    '{8'hC3, 1'b0, 10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0,    16'h0000, 1'b0}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_FORE_RGB;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_bitmap_byte = '0;
  logic                     in_first = 1'b0;
  logic [CB-1:0]            in_origin_x = '0;
  logic [CB-1:0]            in_origin_y = '0;
  logic [CB:0]              in_width_px = '0;
  logic [CB:0]              in_height_px = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CB:0]              out_tile_x;
  logic [CB:0]              out_tile_y;
  logic [15:0]              out_pixel_color;
  logic                     out_last_in_tile;
  logic                     out_last_in_bitmap;

  mono_tile_to_rgb565_expander #(.COORD_BITS(CB)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_bitmap_byte     (in_bitmap_byte),
    .in_first           (in_first),
    .in_origin_x        (in_origin_x),
    .in_origin_y        (in_origin_y),
    .in_width_px        (in_width_px),
    .in_height_px       (in_height_px),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tile_x         (out_tile_x),
    .out_tile_y         (out_tile_y),
    .out_pixel_color    (out_pixel_color),
    .out_last_in_tile   (out_last_in_tile),
    .out_last_in_bitmap (out_last_in_bitmap)
  );

  // Expander model state
  logic [7:0]    tile_cols [8];
  logic [2:0]    cols_held;
  logic [CB:0]   col_off;
  logic [CB:0]   row_off;
  logic [CB-1:0] org_x;
  logic [CB-1:0] org_y;
  logic [CB:0]   bm_width;
  logic [CB:0]   bm_height;
  logic [23:0]   fore_rgb;
  logic [23:0]   back_rgb;

  pixel_t pending_pixels [$];
  pixel_t want_px;
  pixel_t got_px;
  pixel_t table_px;
  bit     use_table_px;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int bytes_sent = 0;
  int errors = 0;
  int shown = 0;

  always #(CLK_HALF) clk = ~clk;

  // Give up long after the slowest correct run would have ended
  initial begin
    #4ms;
    $display("mono_tile_to_rgb565_expander test failed");
    $finish;
  end

  // Reduce 24-bit RGB to 5:6:5 and put the high byte in the low half
  function automatic logic [15:0] panel_colour(input logic [23:0] rgb);
    logic [15:0] c;
    c[15:11] = rgb[23:19];
    c[10:5]  = rgb[15:10];
    c[4:0]   = rgb[7:3];
    return {c[7:0], c[15:8]};
  endfunction

  // Take one column; on the eighth, queue the 64 pixels of the tile
  task automatic absorb_column(input logic [7:0] data, input logic first,
                               input logic [CB-1:0] ox, input logic [CB-1:0] oy,
                               input logic [CB:0] w, input logic [CB:0] h);
    logic [CB:0] tx;
    logic [CB:0] ty;
    int unsigned nxt_col;
    int unsigned nxt_row;
    bit          final_tile;
    logic [15:0] fg;
    logic [15:0] bg;
    pixel_t      px;
    if (first) begin
      org_x     = ox;
      org_y     = oy;
      bm_width  = w;
      bm_height = h;
      cols_held = '0;
      col_off   = '0;
      row_off   = '0;
    end
    tile_cols[cols_held] = data;
    cols_held = cols_held + 3'd1;
    if (cols_held != 3'd0) return;

    tx = {1'b0, org_x} + col_off;
    ty = {1'b0, org_y} + row_off;
    final_tile = 1'b0;
    nxt_col = int'(col_off) + 8;
    nxt_row = int'(row_off);
    if (nxt_col >= int'(bm_width)) begin
      nxt_col = 0;
      nxt_row = int'(row_off) + 8;
      if (nxt_row >= int'(bm_height)) begin
        nxt_row = 0;
        final_tile = 1'b1;
      end
    end
    col_off = nxt_col[CB:0];
    row_off = nxt_row[CB:0];
    fg = panel_colour(fore_rgb);
    bg = panel_colour(back_rgb);

    for (int k = 0; k < 64; k++) begin
      if (use_table_px) begin
        px = table_px;
        px.last_tile   = (k == 63);
        px.last_bitmap = (k == 63) && table_px.last_bitmap;
      end else begin
        px.tx          = tx;
        px.ty          = ty;
        px.colour      = tile_cols[k % 8][k / 8] ? fg : bg;
        px.last_tile   = (k == 63);
        px.last_bitmap = (k == 63) && final_tile;
      end
      pending_pixels.push_back(px);
    end
  endtask

  // Present one column, hold it until taken, then predict
  task automatic send_column(input logic [7:0] data, input logic first,
                             input logic [CB-1:0] ox, input logic [CB-1:0] oy,
                             input logic [CB:0] w, input logic [CB:0] h);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_bitmap_byte <= data;
    in_first       <= first;
    in_origin_x    <= ox;
    in_origin_y    <= oy;
    in_width_px    <= w;
    in_height_px   <= h;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    absorb_column(data, first, ox, oy, w, h);
  endtask

  // Drop valid and wait for every queued pixel to come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Write both colour registers while the block is idle
  task automatic set_colours(input logic [23:0] fg, input logic [23:0] bg);
    hold_until_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FORE_RGB;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_index <= CFG_BACK_RGB;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fore_rgb = fg;
    back_rgb = bg;
  endtask

  function automatic logic [7:0] pick_column();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input pixel_t e, input pixel_t g);
    errors++;
    if (shown < SHOW_MAX) begin
      shown++;
      $display("%0t %s: exp x=%0d y=%0d c=%h lt=%b lb=%b got x=%0d y=%0d c=%h lt=%b lb=%b",
               $realtime, what, e.tx, e.ty, e.colour, e.last_tile, e.last_bitmap,
               g.tx, g.ty, g.colour, g.last_tile, g.last_bitmap);
    end
  endtask

  // Random receiver stall
  always @(posedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  // Check each accepted pixel against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_px = {out_tile_x, out_tile_y, out_pixel_color, out_last_in_tile,
                out_last_in_bitmap};
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected pixel", '0, got_px);
      end else begin
        want_px = pending_pixels.pop_front();
        if (got_px.tx !== want_px.tx || got_px.ty !== want_px.ty ||
            got_px.colour !== want_px.colour ||
            got_px.last_tile !== want_px.last_tile ||
            got_px.last_bitmap !== want_px.last_bitmap)
          note_mismatch("pixel mismatch", want_px, got_px);
      end
    end
  end

  initial begin
    int          kind;
    int          nbytes;
    int          w;
    int          h;
    logic [9:0]  ox;
    logic [9:0]  oy;
    int          phase_end;

    // Model state after reset
    foreach (tile_cols[i]) tile_cols[i] = '0;
    cols_held = '0;
    col_off   = '0;
    row_off   = '0;
    org_x     = '0;
    org_y     = '0;
    bm_width  = '0;
    bm_height = '0;
    fore_rgb  = FORE_RST;
    back_rgb  = BACK_RST;
    use_table_px = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table with reset colours
    foreach (dir_tab[i]) begin
      use_table_px = dir_tab[i].chk;
      table_px = '{dir_tab[i].ex, dir_tab[i].ey, dir_tab[i].ecol, 1'b0, dir_tab[i].elb};
      send_column(dir_tab[i].data, dir_tab[i].first, dir_tab[i].ox, dir_tab[i].oy,
                  dir_tab[i].w, dir_tab[i].h);
    end
    use_table_px = 1'b0;

    // Random phases: colours and idling change between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_colours(24'hFF_FFFF, 24'h00_0000);
        1: set_colours(24'h00_0000, 24'hFF_FFFF);
        default: set_colours(24'($urandom), 24'($urandom));
      endcase
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 86; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 86; end
        default: begin in_idle_pct = 26; out_stall_pct = 26; end
      endcase
      phase_end = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < phase_end) begin
        kind = $urandom_range(9);
        ox = 10'($urandom_range(1023));
        oy = 10'($urandom_range(1023));
        if (kind <= 6) begin
          // whole bitmap, sometimes followed by a repeat of its first tiles
          w = $urandom_range(1, 24);
          h = $urandom_range(1, 24);
          nbytes = ((w + 7) / 8) * ((h + 7) / 8) * 8;
          if (kind == 6) nbytes += 8 * $urandom_range(1, 2);
          for (int b = 0; b < nbytes; b++)
            send_column(pick_column(), b == 0, ox, oy, 11'(w), 11'(h));
        end else if (kind == 7) begin
          // bitmap of any size, with only a random number of its columns sent
          w = $urandom_range(1, 1024);
          h = $urandom_range(1, 1024);
          nbytes = $urandom_range(1, 20);
          for (int b = 0; b < nbytes; b++)
            send_column(pick_column(), b == 0, ox, oy, 11'(w), 11'(h));
        end else if (kind == 8) begin
          // columns without a start, geometry fields to be ignored
          nbytes = $urandom_range(1, 12);
          for (int b = 0; b < nbytes; b++)
            send_column(pick_column(), 1'b0, 10'($urandom_range(1023)),
                        10'($urandom_range(1023)), 11'($urandom_range(1, 1024)),
                        11'($urandom_range(1, 1024)));
        end else begin
          hold_until_drained();
        end
      end
    end

    hold_until_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_pixels.size() != 0)
      note_mismatch("pixel never seen", pending_pixels[0], '0);

    if (errors == 0) begin
      $display("mono_tile_to_rgb565_expander test passed");
    end else begin
      $display("mono_tile_to_rgb565_expander test failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/mtre_pkg.sv
design/mono_tile_to_rgb565_expander.sv
design/mtre_checker.sv
tb/tb_top.sv
